// ===== rtl/core/pcx_rle_plane_decoder_top_assert.svh =====
// assertion macros for the pcx run-length plane decoder
// used by modules clocked on i_clk with synchronous active-low i_rst_n
`ifndef PCX_RLE_PLANE_DECODER_TOP_ASSERT_SVH
`define PCX_RLE_PLANE_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define PCX_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pcx assertion failed");

// next-cycle implication
`define PCX_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pcx assertion failed");

`endif

// ===== rtl/core/pcx_pkg.sv =====
// shared types and constants of the pcx run-length plane decoder
// no dependencies
`timescale 1ns / 1ps

package pcx_pkg;

    localparam logic [7:0] RUN_MARK   = 8'hC0;
    localparam logic [7:0] COUNT_MASK = 8'h3F;

    localparam logic [1:0] CFG_BYTES_PER_LINE = 2'd0;
    localparam logic [1:0] CFG_IMAGE_WIDTH    = 2'd1;
    localparam logic [1:0] CFG_IMAGE_HEIGHT   = 2'd2;
    localparam logic [1:0] CFG_PLANE_COUNT    = 2'd3;

    localparam logic [15:0] RST_BYTES_PER_LINE = 16'd2;
    localparam logic [15:0] RST_IMAGE_WIDTH    = 16'd1;
    localparam logic [15:0] RST_IMAGE_HEIGHT   = 16'd1;
    localparam logic [2:0]  RST_PLANE_COUNT    = 3'd1;

    localparam int CMD_DEPTH_DEF = 2;

    typedef struct packed {
        logic [15:0] bytes_per_line;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [2:0]  plane_count;
    } t_cfg;

    // one decoded run: a literal is a run of one
    typedef struct packed {
        logic [7:0] value;
        logic [5:0] count;
    } t_cmd;

endpackage

// ===== rtl/core/pcx_rle_plane_decoder_top.sv =====
// top level of the pcx run-length plane decoder: config registers and wiring
// depends on pcx_pkg, pcx_front, pcx_cmd_fifo, pcx_back
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------------------
//  input    | in        | i_in_valid / o_in_stall | i_code_byte
//  output   | out       | o_out_valid/ i_out_stall| pixel_value column plane line ends
//  config   | in        | i_cfg_valid/ o_cfg_ready| i_cfg_index i_cfg_data
//
// the front takes one code byte per cycle while the command queue has room
// a run of n copies occupies the back for up to n bytes, one placed byte per cycle
// while the output is not stalled (padding bytes too), ending early at the line end;
// a literal places one byte; the queue holds CMD_DEPTH commands
// a result waits in the output register; placing continues once it is taken
// reset is synchronous and clears all position state
`timescale 1ns / 1ps

module pcx_rle_plane_decoder_top
    import pcx_pkg::*;
#(
    parameter int CMD_DEPTH = CMD_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_code_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_pixel_value,
    output logic [15:0] o_column,
    output logic [1:0]  o_plane,
    output logic [15:0] o_line,
    output logic        o_run_end,
    output logic        o_frame_end,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg r_cfg;
    t_cmd push_cmd, head_cmd;
    logic push, pop, q_full, q_nonempty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bytes_per_line <= RST_BYTES_PER_LINE;
            r_cfg.image_width    <= RST_IMAGE_WIDTH;
            r_cfg.image_height   <= RST_IMAGE_HEIGHT;
            r_cfg.plane_count    <= RST_PLANE_COUNT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BYTES_PER_LINE: r_cfg.bytes_per_line <= i_cfg_data;
                CFG_IMAGE_WIDTH:    r_cfg.image_width    <= i_cfg_data;
                CFG_IMAGE_HEIGHT:   r_cfg.image_height   <= i_cfg_data;
                CFG_PLANE_COUNT:    r_cfg.plane_count    <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    pcx_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_code_byte (i_code_byte),
        .i_q_full    (q_full),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    pcx_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_wdata    (push_cmd),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_rdata    (head_cmd)
    );

    pcx_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd_valid   (q_nonempty),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_value (o_pixel_value),
        .o_column      (o_column),
        .o_plane       (o_plane),
        .o_line        (o_line),
        .o_run_end     (o_run_end),
        .o_frame_end   (o_frame_end)
    );

endmodule

// ===== rtl/core/pcx_cmd_fifo.sv =====
// small register queue of run commands between front and back
// depends on pcx_pkg
`timescale 1ns / 1ps

module pcx_cmd_fifo
    import pcx_pkg::*;
#(
    parameter int DEPTH = CMD_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_wdata,
    input  logic i_pop,
    output logic o_full,
    output logic o_nonempty,
    output t_cmd o_rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;
    logic          push_ok, pop_ok;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_rdata    = r_mem[r_rptr];
    assign push_ok    = i_push && !o_full;
    assign pop_ok     = i_pop && o_nonempty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push_ok) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (pop_ok) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + CW'(1);
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

// ===== rtl/core/pcx_front.sv =====
// front end: takes code bytes, splits headers from values and literals
// depends on pcx_pkg; feeds pcx_cmd_fifo
`timescale 1ns / 1ps

module pcx_front
    import pcx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_code_byte,
    input  logic       i_q_full,
    output logic       o_in_stall,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic       r_await, n_await;
    logic [5:0] r_run_len, n_run_len;
    logic       accept;
    logic       is_header;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign is_header  = (i_code_byte & RUN_MARK) == RUN_MARK;

    always_comb begin
        n_await     = r_await;
        n_run_len   = r_run_len;
        o_push      = 1'b0;
        o_cmd.value = i_code_byte;
        o_cmd.count = 6'd1;
        if (accept) begin
            if (r_await) begin
                n_await     = 1'b0;
                n_run_len   = '0;
                o_cmd.count = r_run_len;
                // a zero count swallows the value byte
                o_push      = (r_run_len != '0);
            end else if (is_header) begin
                n_await   = 1'b1;
                n_run_len = 6'(i_code_byte & COUNT_MASK);
            end else begin
                o_push = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await   <= 1'b0;
            r_run_len <= '0;
        end else begin
            r_await   <= n_await;
            r_run_len <= n_run_len;
        end
    end

endmodule

// ===== rtl/core/pcx_back.sv =====
// back end: expands run commands into placed bytes and tracks positions
// depends on pcx_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "pcx_rle_plane_decoder_top_assert.svh"

module pcx_back
    import pcx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_pixel_value,
    output logic [15:0] o_column,
    output logic [1:0]  o_plane,
    output logic [15:0] o_line,
    output logic        o_run_end,
    output logic        o_frame_end
);

    logic [15:0] r_bp, r_row;
    logic [1:0]  r_plane;
    logic        r_complete;
    logic [5:0]  r_done;
    logic        r_ov;
    logic [7:0]  r_pix;
    logic [15:0] r_col, r_line;
    logic [1:0]  r_opl;
    logic        r_rend, r_fend;

    logic [15:0] bpl_e, w_e, h_e, lastcol;
    logic [2:0]  np_e;
    logic [16:0] bp1, row1;
    logic [2:0]  pl1;
    logic [5:0]  done1;
    logic        line_wrap, plane_wrap, row_wrap;
    logic        emit, advance, drop, cnt_last, cmd_last, out_free;

    assign bpl_e = (i_cfg.bytes_per_line == '0) ? 16'd1 : i_cfg.bytes_per_line;
    assign w_e   = (i_cfg.image_width == '0) ? 16'd1 : i_cfg.image_width;
    assign h_e   = (i_cfg.image_height == '0) ? 16'd1 : i_cfg.image_height;
    assign np_e  = (i_cfg.plane_count == '0) ? 3'd1 :
                   (i_cfg.plane_count > 3'd4) ? 3'd4 : i_cfg.plane_count;
    assign lastcol = ((w_e < bpl_e) ? w_e : bpl_e) - 16'd1;

    assign bp1   = {1'b0, r_bp} + 17'd1;
    assign pl1   = {1'b0, r_plane} + 3'd1;
    assign row1  = {1'b0, r_row} + 17'd1;
    assign done1 = r_done + 6'd1;

    // a 16-bit position that rolls over also ends the line
    assign line_wrap  = bp1 >= {1'b0, bpl_e};
    assign plane_wrap = pl1 >= np_e;
    assign row_wrap   = row1 >= {1'b0, h_e};

    assign emit     = r_bp < w_e;
    assign out_free = !r_ov || !i_out_stall;
    assign drop     = i_cmd_valid && r_complete;
    assign advance  = i_cmd_valid && !r_complete && out_free;
    assign cnt_last = (done1 == i_cmd.count);
    assign cmd_last = cnt_last || line_wrap;
    assign o_pop    = drop || (advance && cmd_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bp       <= '0;
            r_plane    <= '0;
            r_row      <= '0;
            r_complete <= 1'b0;
            r_done     <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (advance && emit) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (drop) begin
                r_done <= '0;
            end else if (advance) begin
                r_done <= cmd_last ? 6'd0 : done1;
                if (line_wrap) begin
                    r_bp <= '0;
                    if (plane_wrap) begin
                        r_plane <= '0;
                        if (row_wrap) begin
                            r_row      <= '0;
                            r_complete <= 1'b1;
                        end else begin
                            r_row <= row1[15:0];
                        end
                    end else begin
                        r_plane <= pl1[1:0];
                    end
                end else begin
                    r_bp <= bp1[15:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_pix  <= i_cmd.value;
            r_col  <= r_bp;
            r_opl  <= r_plane;
            r_line <= r_row;
            // later bytes of this run stay in this line; past the width none show
            r_rend <= cnt_last || (bp1 >= {1'b0, w_e}) || line_wrap;
            r_fend <= (r_bp == lastcol) && plane_wrap && row_wrap;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_pixel_value = r_pix;
    assign o_column      = r_col;
    assign o_plane       = r_opl;
    assign o_line        = r_line;
    assign o_run_end     = r_rend;
    assign o_frame_end   = r_fend;

    `PCX_ASSERT_NXT(a_last_line_completes, advance && line_wrap && plane_wrap && row_wrap, r_complete)
    `PCX_ASSERT_NXT(a_silent_after_complete, r_complete && !r_ov, !r_ov)
    `PCX_ASSERT_IMP(a_done_below_count, i_cmd_valid && !r_complete, r_done < i_cmd.count)

endmodule
